// ----- design/rtlcg_pkg.sv -----
// ----------------------------------------------------------------------------
// rtlcg_pkg
// Shared types and constants of the randomized timeout generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rtlcg_pkg;

	localparam int unsigned MAX_LOG_INTERVAL_DEF = 16;

	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;

	localparam int unsigned BASE_MS_W = 9;
	localparam logic [BASE_MS_W-1:0] BASE_MS = 9'd400;

	localparam int unsigned DUR_W = 27;
	localparam logic [DUR_W-1:0] DURATION_MAX = 27'h7FFFFFF;

	localparam int unsigned RVAL_W = 21;
	localparam int unsigned DIV_STEPS = 2;
	localparam int unsigned DIV_K_W = 1;
	localparam logic [DIV_K_W-1:0] DIV_K_TOP = 1'(DIV_STEPS - 1);

	// 400 is 25 shifted left by four; the quotient by 25 comes from a
	// reciprocal multiply that is exact for every 17-bit operand.
	localparam int unsigned DIV_PRE_SHIFT = 4;
	localparam int unsigned RECIP_W = 18;
	localparam logic [RECIP_W-1:0] RECIP_25 = 18'd167773;
	localparam int unsigned RECIP_SHIFT = 22;
	localparam int unsigned QUO_W = 13;

	typedef struct packed {
		logic [2:0] slot;
		logic [4:0] log_interval;
	} in_t;

	typedef struct packed {
		logic [2:0]       slot_out;
		logic [DUR_W-1:0] duration_ms;
	} out_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add_first;
		logic add_second;
		logic div_init;
		logic div_step;
		logic shift;
		logic sum;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/rtlcg_dp.sv -----
// ----------------------------------------------------------------------------
// rtlcg_dp
// Datapath: seed register, generator multiply and add, modulo unit, result.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlcg_dp #(
	parameter int unsigned MAX_LOG_INTERVAL = rtlcg_pkg::MAX_LOG_INTERVAL_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [31:0]     cfg_wdata,
	input  wire rtlcg_pkg::in_t  in_data,
	input  wire rtlcg_pkg::cmd_t cmd,
	output rtlcg_pkg::sts_t      sts,
	output rtlcg_pkg::out_t      out_data
);

	localparam int unsigned BASE_W = rtlcg_pkg::BASE_MS_W + MAX_LOG_INTERVAL;
	localparam int unsigned CALC_W = (BASE_W + 2 > rtlcg_pkg::DUR_W) ?
		BASE_W + 2 : rtlcg_pkg::DUR_W;
	localparam int unsigned RV_W = rtlcg_pkg::RVAL_W;
	localparam int unsigned PRE_W = rtlcg_pkg::RVAL_W - rtlcg_pkg::DIV_PRE_SHIFT;
	localparam int unsigned RECIP_PROD_W = PRE_W + rtlcg_pkg::RECIP_W;

	logic [31:0]                       seed_q;
	logic [31:0]                       src_q;
	logic [31:0]                       operand_q;
	logic [31:0]                       prod_q;
	logic [31:0]                       next_seed;
	logic [2:0]                        slot_q;
	logic [4:0]                        lg_q;
	logic [rtlcg_pkg::RVAL_W-1:0]      rval_q;
	logic [rtlcg_pkg::RVAL_W-1:0]      rem_q;
	logic [rtlcg_pkg::DIV_K_W-1:0]     k_q;
	logic [rtlcg_pkg::QUO_W-1:0]       quo_q;
	logic [BASE_W-1:0]                 mod_q;
	logic [rtlcg_pkg::RVAL_W-1:0]      low_mask;
	logic [RECIP_PROD_W-1:0]           recip_prod;
	logic [rtlcg_pkg::RVAL_W-1:0]      quo_mul;
	logic [BASE_W-1:0]                 base;
	logic [CALC_W-1:0]                 dur;
	logic [4:0]                        lg_in;

	assign next_seed  = prod_q + rtlcg_pkg::LCG_ADD;
	assign low_mask   = ~({rtlcg_pkg::RVAL_W{1'b1}} << lg_q);
	assign recip_prod = RECIP_PROD_W'(rem_q[rtlcg_pkg::RVAL_W-1:rtlcg_pkg::DIV_PRE_SHIFT]) *
		RECIP_PROD_W'(rtlcg_pkg::RECIP_25);
	assign quo_mul    = RV_W'(quo_q) * RV_W'(rtlcg_pkg::BASE_MS);
	assign base       = BASE_W'(rtlcg_pkg::BASE_MS) << lg_q;
	assign dur        = (CALC_W'(base) << 1) + CALC_W'(mod_q);
	assign lg_in      = (in_data.log_interval > 5'(MAX_LOG_INTERVAL)) ?
		5'(MAX_LOG_INTERVAL) : in_data.log_interval;
	assign sts.div_last = (k_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			src_q  <= '0;
		end else begin
			if (cfg_we) begin
				src_q <= cfg_wdata;
			end
			if (cmd.add_first || cmd.add_second) begin
				seed_q <= next_seed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			operand_q <= (seed_q == '0) ? src_q : seed_q;
			slot_q    <= in_data.slot;
			lg_q      <= lg_in;
		end
		if (cmd.mul) begin
			prod_q <= operand_q * rtlcg_pkg::LCG_MUL;
		end
		if (cmd.add_first) begin
			operand_q    <= next_seed;
			rval_q[20:10] <= next_seed[26:16];
		end
		if (cmd.add_second) begin
			rval_q[9:0] <= next_seed[25:16];
		end
		if (cmd.div_init) begin
			rem_q <= rval_q >> lg_q;
			k_q   <= rtlcg_pkg::DIV_K_TOP;
		end
		if (cmd.div_step) begin
			if (k_q == '0) begin
				rem_q <= rem_q - quo_mul;
			end else begin
				quo_q <= recip_prod[rtlcg_pkg::RECIP_SHIFT+rtlcg_pkg::QUO_W-1:
					rtlcg_pkg::RECIP_SHIFT];
			end
			k_q <= k_q - 1'b1;
		end
		if (cmd.shift) begin
			mod_q <= (BASE_W'(rem_q[rtlcg_pkg::BASE_MS_W-1:0]) << lg_q) |
				BASE_W'(rval_q & low_mask);
		end
		if (cmd.sum) begin
			out_data.slot_out <= slot_q;
			if (dur > CALC_W'(rtlcg_pkg::DURATION_MAX)) begin
				out_data.duration_ms <= rtlcg_pkg::DURATION_MAX;
			end else begin
				out_data.duration_ms <= dur[rtlcg_pkg::DUR_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/rtlcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtlcg_ctrl
// Controller: sequences one transaction through the datapath and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlcg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire rtlcg_pkg::sts_t sts,
	output rtlcg_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL1  = 4'd1;
	localparam logic [3:0] S_ADD1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_ADD2  = 4'd4;
	localparam logic [3:0] S_DIVI  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_SHIFT = 4'd7;
	localparam logic [3:0] S_SUM   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul = 1'b1;
				state_d = S_ADD1;
			end
			S_ADD1: begin
				cmd.add_first = 1'b1;
				state_d       = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul = 1'b1;
				state_d = S_ADD2;
			end
			S_ADD2: begin
				cmd.add_second = 1'b1;
				state_d        = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = S_SUM;
			end
			S_SUM: begin
				if (out_free) begin
					cmd.sum = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.sum) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_sum_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum |-> (!out_valid_q || out_ready))
		else $error("Result written over a transaction not yet taken.");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_MUL1))
		else $error("Accepted transaction did not start the generator.");

	a_div_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_last) |=> (state_q == S_SHIFT))
		else $error("Modulo unit did not hand over after its last step.");

	a_sum_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum |=> out_valid_q)
		else $error("Result written without raising valid.");

endmodule

`default_nettype wire

// ----- design/randomized_timeout_lcg.sv -----
// ----------------------------------------------------------------------------
// randomized_timeout_lcg
// Randomized timeout generator: two generator steps, a modulo and a sum.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_data (slot, log_interval)
//   out      output     out_valid / out_ready  out_data (slot_out, duration_ms)
//   cfg      input      cfg_we                 cfg_wdata (seed source)
//
// A transaction runs from acceptance to its result being written through the
// sequencer states: two multiply and add steps, a reciprocal multiply and
// a subtraction for the remainder by 400, then the shift and the sum. The
// sequencer returns to idle after the write and accepts only there, so no
// new transaction is taken before the last result is written, though one is
// taken while a result waits. A result not yet taken holds the next one in
// its final step. Reset clears the seed, the seed source and all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module randomized_timeout_lcg #(
	parameter int unsigned MAX_LOG_INTERVAL = rtlcg_pkg::MAX_LOG_INTERVAL_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire rtlcg_pkg::in_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output rtlcg_pkg::out_t     out_data
);

	rtlcg_pkg::cmd_t cmd;
	rtlcg_pkg::sts_t sts;

	rtlcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtlcg_dp #(
		.MAX_LOG_INTERVAL (MAX_LOG_INTERVAL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
